/* rtl/matrix3_inverse_top_assert.svh */
// Assertion macros shared by the matrix inverse RTL
`ifndef MATRIX3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define MI3_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define MI3_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mi3inv_pkg.sv */
// Types, constants and helpers for the 3x3 matrix inverse pipeline
package mi3inv_pkg;

  localparam int IN_W     = 16;
  localparam int N_ELEM   = 9;
  localparam int COF_W    = 33;
  localparam int DET_W    = 49;
  localparam int DEN_W    = 48;
  localparam int TOL_W    = 49;
  localparam int NUM_W    = 56;
  localparam int QUO_W    = 32;
  localparam int RES_W    = 32;
  localparam int FRAC_SH  = 24;
  localparam int DIV_BITS_DEF = 2;

  // register map
  localparam logic [0:0] REG_DET_TOL = 1'b0;
  localparam logic [TOL_W-1:0] TOL_RESET = 49'd17;

  // cofactor k = m[a]*m[b] - m[c]*m[d], flat row-major indexes
  localparam int COF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };
  // cofactors used in the first-row determinant expansion
  localparam int DET_COF [3] = '{0, 3, 6};

  typedef logic signed [IN_W-1:0]  elem_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [DET_W-1:0] det_t;

  typedef struct packed {
    logic                           sing;
    logic [N_ELEM-1:0]              neg;
    logic [N_ELEM-1:0][RES_W-1:0]   csat;
  } sb_t;

  // clamp a cofactor to the signed 32-bit range
  function automatic logic [RES_W-1:0] sat32(cof_t v);
    logic [RES_W-1:0] r;
    if (!v[COF_W-1] && v[COF_W-2]) r = 32'h7FFF_FFFF;
    else if (v[COF_W-1] && !v[COF_W-2]) r = 32'h8000_0000;
    else r = v[RES_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/mi3inv_div.sv */
// Pipelined restoring divider: 32-bit quotient with overflow flag
module mi3inv_div #(
  parameter int DivBits = mi3inv_pkg::DIV_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mi3inv_pkg::NUM_W-1:0]  num,
  input  logic [mi3inv_pkg::DEN_W-1:0]  den,
  output logic [mi3inv_pkg::QUO_W-1:0]  quo,
  output logic                          ovf
);
  import mi3inv_pkg::*;

  localparam int NSt  = QUO_W / DivBits;
  localparam int RemW = DEN_W + 1;

  logic [RemW-1:0]  rem_q [NSt];
  logic [DEN_W-1:0] den_q [NSt];
  logic [QUO_W-1:0] low_q [NSt+1];
  logic             ovf_q [NSt+1];

  // entry: upper numerator bits seed the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= RemW'(num[NUM_W-1:QUO_W]);
      low_q[0] <= num[QUO_W-1:0];
      den_q[0] <= den;
      ovf_q[0] <= RemW'(num[NUM_W-1:QUO_W]) >= RemW'(den);
    end
  end

  // each stage retires DivBits quotient bits; quotient shifts into low word
  for (genvar s = 0; s < NSt; s++) begin : g_st
    logic [RemW-1:0]  r_c;
    logic [QUO_W-1:0] l_c;

    always_comb begin
      r_c = rem_q[s];
      l_c = low_q[s];
      for (int j = 0; j < DivBits; j++) begin
        r_c = {r_c[RemW-2:0], l_c[QUO_W-1]};
        l_c = {l_c[QUO_W-2:0], 1'b0};
        if (r_c >= RemW'(den_q[s])) begin
          r_c    = r_c - RemW'(den_q[s]);
          l_c[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        low_q[s+1] <= l_c;
        ovf_q[s+1] <= ovf_q[s];
      end
    end

    if (s < NSt - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s+1] <= r_c;
          den_q[s+1] <= den_q[s];
        end
      end
    end
  end

  assign quo = low_q[NSt];
  assign ovf = ovf_q[NSt];

endmodule

/* rtl/matrix3_inverse_top.sv */
// 3x3 matrix inverse by adjugate and determinant, fully pipelined
// Throughput: one matrix per cycle unless the output stalls; the divider retires DivBits
// quotient bits per stage.
// A stall at the output freezes every stage; nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline and sets det_tolerance to 17.
module matrix3_inverse_top #(
  parameter int DivBits = mi3inv_pkg::DIV_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22 (16b each, low first)
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22 (32b each, low first)
  output logic         m_tuser,   // singular
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import mi3inv_pkg::*;
  `include "matrix3_inverse_top_assert.svh"

  localparam int DivLat   = QUO_W / DivBits + 1;
  localparam int FrontLat = 7;
  localparam int VldN     = FrontLat + DivLat;

  // config register
  logic [TOL_W-1:0] det_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_tol <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_DET_TOL) begin
      det_tol <= pwdata[TOL_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {{(64-TOL_W){1'b0}}, det_tol};

  // global advance: output register empty or being taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [VldN-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VldN-2:0], s_tvalid};
    end
  end

  // front end datapath
  elem_t               m1   [N_ELEM];
  logic signed [31:0]  pa2  [N_ELEM];
  logic signed [31:0]  pb2  [N_ELEM];
  elem_t               r02  [3];
  cof_t                c3   [N_ELEM];
  elem_t               r03  [3];
  det_t                t4   [3];
  cof_t                c4   [N_ELEM];
  det_t                det5;
  cof_t                c5   [N_ELEM];
  logic [DEN_W-1:0]    adet6;
  logic                dneg6;
  logic [N_ELEM-1:0]   cneg6;
  logic [31:0]         cabs6 [N_ELEM];
  logic [RES_W-1:0]    csat6 [N_ELEM];
  logic [NUM_W-1:0]    num7  [N_ELEM];
  logic [DEN_W-1:0]    den7;
  sb_t                 sb7;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: capture entries
      for (int i = 0; i < N_ELEM; i++) begin
        m1[i] <= elem_t'(s_tdata[IN_W*i +: IN_W]);
      end
      // stage 2: cofactor products
      for (int k = 0; k < N_ELEM; k++) begin
        pa2[k] <= m1[COF_IDX[k][0]] * m1[COF_IDX[k][1]];
        pb2[k] <= m1[COF_IDX[k][2]] * m1[COF_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) r02[j] <= m1[j];
      // stage 3: cofactors
      for (int k = 0; k < N_ELEM; k++) c3[k] <= cof_t'(pa2[k]) - cof_t'(pb2[k]);
      r03 <= r02;
      // stage 4: determinant terms along the first row
      for (int j = 0; j < 3; j++) t4[j] <= r03[j] * c3[DET_COF[j]];
      c4 <= c3;
      // stage 5: determinant
      det5 <= t4[0] + t4[1] + t4[2];
      c5   <= c4;
      // stage 6: magnitudes and signs
      adet6 <= det5[DET_W-1] ? DEN_W'(-det5) : DEN_W'(det5);
      dneg6 <= det5[DET_W-1];
      for (int k = 0; k < N_ELEM; k++) begin
        cneg6[k] <= c5[k][COF_W-1];
        cabs6[k] <= c5[k][COF_W-1] ? 32'(-c5[k]) : 32'(c5[k]);
        csat6[k] <= sat32(c5[k]);
      end
      // stage 7: rounded numerators and singular test
      for (int k = 0; k < N_ELEM; k++) begin
        num7[k]        <= NUM_W'({cabs6[k], {FRAC_SH{1'b0}}}) + NUM_W'(adet6[DEN_W-1:1]);
        sb7.neg[k]     <= cneg6[k] ^ dneg6;
        sb7.csat[k]    <= csat6[k];
      end
      sb7.sing <= {1'b0, adet6} <= det_tol;
      den7     <= adet6;
    end
  end

  // dividers, one per element
  logic [QUO_W-1:0]  quo [N_ELEM];
  logic [N_ELEM-1:0] ovf;

  for (genvar k = 0; k < N_ELEM; k++) begin : g_div
    mi3inv_div #(.DivBits(DivBits)) u_div (
      .clk (clk),
      .en  (en),
      .num (num7[k]),
      .den (den7),
      .quo (quo[k]),
      .ovf (ovf[k])
    );
  end

  // sideband delayed alongside the dividers
  sb_t sbd [DivLat];

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[0] <= sb7;
      for (int i = 1; i < DivLat; i++) sbd[i] <= sbd[i-1];
    end
  end

  // sign, saturation and singular select
  logic [N_ELEM-1:0][RES_W-1:0] res;

  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      if (sbd[DivLat-1].sing) begin
        res[k] = sbd[DivLat-1].csat[k];
      end else if (sbd[DivLat-1].neg[k]) begin
        res[k] = (ovf[k] || quo[k] > 32'h8000_0000) ? 32'h8000_0000 : -quo[k];
      end else begin
        res[k] = (ovf[k] || quo[k][QUO_W-1]) ? 32'h7FFF_FFFF : quo[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[VldN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res;
      m_tuser <= sbd[DivLat-1].sing;
    end
  end

  `MI3_CHECK_NEXT(a_zero_det_sing, en && vld[5] && adet6 == '0, sb7.sing, "zero determinant not singular")
  `MI3_CHECK_NEXT(a_bubble_out, en && !vld[VldN-1], !m_tvalid, "output valid without pipeline item")
  `MI3_CHECK_NEXT(a_stall_hold, !en, $stable(vld), "pipeline moved during stall")

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the 3x3 matrix inverse pipeline
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mi3inv_pkg::*;

  localparam int NUM_PHASES = 4;
  localparam int ITEMS_PER_PHASE = 660;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [63:0] TOL_MASK = 64'h0001_FFFF_FFFF_FFFF;

  // expected inverse of one matrix
  typedef struct {
    logic [31:0] r[9];
    logic        sing;
  } inverse_t;

  // scoreboard: predicts each inverse and compares with the output stream
  class inverse_scoreboard;
    longint   tolerance;
    inverse_t pending[$];
    int       errors;

    function new();
      tolerance = 17;
      errors = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // adjugate/det rounded half away from zero; clamped adjugate if singular
    function inverse_t predict_inverse(logic [143:0] d);
      longint m[9];
      longint c[9];
      longint det, absdet, num, an, q, rv;
      inverse_t e;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
      c[0] = m[4] * m[8] - m[5] * m[7];
      c[1] = m[2] * m[7] - m[1] * m[8];
      c[2] = m[1] * m[5] - m[2] * m[4];
      c[3] = m[5] * m[6] - m[3] * m[8];
      c[4] = m[0] * m[8] - m[2] * m[6];
      c[5] = m[2] * m[3] - m[0] * m[5];
      c[6] = m[3] * m[7] - m[4] * m[6];
      c[7] = m[1] * m[6] - m[0] * m[7];
      c[8] = m[0] * m[4] - m[1] * m[3];
      det = m[0] * c[0] + m[1] * c[3] + m[2] * c[6];
      absdet = (det < 0) ? -det : det;
      e.sing = (absdet <= tolerance);
      for (int i = 0; i < 9; i++) begin
        if (e.sing) begin
          rv = clamp32(c[i]);
        end else begin
          num = c[i] * 64'sd16777216;
          an = (num < 0) ? -num : num;
          q = (an + absdet / 2) / absdet;
          rv = clamp32(((num < 0) != (det < 0)) ? -q : q);
        end
        e.r[i] = rv[31:0];
      end
      return e;
    endfunction

    function void note_matrix(logic [143:0] d);
      pending.push_back(predict_inverse(d));
    endfunction

    function void check_result(logic [287:0] data, logic sing);
      inverse_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output transfer data=%h singular=%b", $realtime, data, sing);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (data[32*i +: 32] !== e.r[i]) begin
          $display("%0t: r%0d%0d expected %h actual %h", $realtime, i / 3, i % 3,
                   e.r[i], data[32*i +: 32]);
          errors++;
        end
      if (sing !== e.sing) begin
        $display("%0t: singular expected %b actual %b", $realtime, e.sing, sing);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [287:0] m_tdata;
  logic         m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [0:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  inverse_scoreboard sb = new();
  bit src_burst = 1'b0;
  bit snk_burst = 1'b0;

  matrix3_inverse_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // APB write: setup then access cycle
  task automatic write_tolerance(logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_DET_TOL;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.tolerance = longint'(value & TOL_MASK);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one input transfer after a random gap
  task automatic send_matrix(logic [143:0] d);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_matrix(d);
  endtask

  function automatic logic [143:0] pack_matrix(int e[9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'(e[i]);
    return d;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  // random matrix of a randomly chosen kind
  function automatic logic [143:0] random_matrix();
    int e[9];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (kind)
        3, 4:    e[i] = $urandom_range(0, 1024) - 512;
        6:       e[i] = $urandom_range(0, 8) - 4;
        7:       e[i] = (i % 4 == 0) ? int'($urandom_range(0, 65535)) - 32768
                                     : int'($urandom_range(0, 64)) - 32;
        8:       e[i] = $urandom_range(0, 32766) - 16383;
        9:       e[i] = pick_extreme();
        default: e[i] = int'($urandom_range(0, 65535)) - 32768;
      endcase
    end
    // dependent rows: duplicate or sum
    if (kind == 5) for (int j = 0; j < 3; j++) e[6 + j] = e[j];
    if (kind == 8) for (int j = 0; j < 3; j++) e[6 + j] = e[j] + e[3 + j];
    return pack_matrix(e);
  endfunction

  task automatic send_directed();
    int z[9] = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    int ident[9] = '{256, 0, 0, 0, 256, 0, 0, 0, 256};
    int nident[9] = '{-256, 0, 0, 0, -256, 0, 0, 0, -256};
    int dmax[9] = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};
    int dmin[9] = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
    int amax[9] = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    int amin[9] = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    int unit[9] = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    int edge18[9] = '{1, 0, 0, 0, 1, 0, 0, 0, 18};
    int edge17[9] = '{1, 0, 0, 0, 1, 0, 0, 0, -17};
    int small16[9] = '{16, 0, 0, 0, 16, 0, 0, 0, 16};
    int satp[9] = '{32, 30000, 0, 32, 30001, 0, 0, 0, 1};
    int satn[9] = '{-32, 30000, 0, -32, 30001, 0, 0, 0, 1};
    int rank2[9] = '{300, -700, 1200, 300, -700, 1200, 5, 9, -4};
    int mixed[9] = '{-32768, 32767, 1, 32767, -32768, -1, 1, -1, 32767};
    int gen[9] = '{512, -128, 77, 3, 900, -450, -256, 64, 1000};
    send_matrix(pack_matrix(z));
    send_matrix(pack_matrix(ident));
    send_matrix(pack_matrix(nident));
    send_matrix(pack_matrix(dmax));
    send_matrix(pack_matrix(dmin));
    send_matrix(pack_matrix(amax));
    send_matrix(pack_matrix(amin));
    send_matrix(pack_matrix(unit));
    send_matrix(pack_matrix(edge18));
    send_matrix(pack_matrix(edge17));
    send_matrix(pack_matrix(small16));
    send_matrix(pack_matrix(satp));
    send_matrix(pack_matrix(satn));
    send_matrix(pack_matrix(rank2));
    send_matrix(pack_matrix(mixed));
    send_matrix(pack_matrix(gen));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // output side: random stalls, check every transfer
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = snk_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
      if ($urandom_range(0, 49) == 0) snk_burst = ~snk_burst;
    end
  end

  // main sequence
  initial begin
    logic [63:0] tol_set[NUM_PHASES];
    tol_set[0] = 64'd0;
    tol_set[1] = 64'd281474976710656;
    tol_set[2] = {$urandom(), $urandom()};
    tol_set[3] = 64'd17;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      send_matrix(random_matrix());
      if ($urandom_range(0, 49) == 0) src_burst = ~src_burst;
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_tolerance(tol_set[p]);
      if (p == 0) send_directed();
      for (int n = 0; n < ITEMS_PER_PHASE / 2; n++) begin
        send_matrix(random_matrix());
        if ($urandom_range(0, 49) == 0) src_burst = ~src_burst;
      end
    end
    wait_drained();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
